// ===== design/ede_pkg.sv =====
`default_nettype none

package ede_pkg;

    // payload widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int DIST_W = 7;

    // opcodes
    localparam logic [OP_W-1:0] OP_SRC  = 2'd0;
    localparam logic [OP_W-1:0] OP_TGT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // largest distance the result field can carry
    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    // entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one queued command
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_byte;
    } cmd_t;

    // push side of the command queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    // pop side of the command queue
    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

// ===== design/ede_if.sv =====
`default_nettype none

// input word channel
interface ede_in_if;
    logic                        valid;
    logic                        ready;
    logic [ede_pkg::OP_W-1:0]    opcode;
    logic [ede_pkg::CHAR_W-1:0]  char_byte;

    modport source (output valid, output opcode, output char_byte, input ready);
    modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

// result word channel
interface ede_out_if;
    logic                        valid;
    logic                        ready;
    logic [ede_pkg::DIST_W-1:0]  distance;
    logic                        overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/edit_distance_engine_top.sv =====
// Levenshtein edit distance engine.
// in_ch carries command words: opcode 0 appends char_byte to the source
// string, opcode 1 appends it to the target string, opcode 2 computes the
// distance, emits one word on out_ch and clears both strings. Opcode 3 is
// accepted and ignored. Bytes past MAX_LEN are dropped and flagged in the
// overflow bit of the next result.
// A four-entry command queue sits behind in_ch, so words are accepted one
// per cycle while it has room. An append is done in the back end's idle
// state. A compute walks the cost row one cell per cycle through registered
// reads of the target and row stores, turning around through the row-start
// state between rows; with either string empty the walk is skipped. The
// result then sits in an output register until out_ch takes it, while the
// queue keeps filling; a stalled receiver holds back the next compute only.
// Reset clears the queue, both lengths, the overflow flag and the output
// valid bit; the character and row stores need no clearing.
`default_nettype none

module edit_distance_engine_top #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ede_in_if.sink     in_ch,
    ede_out_if.source  out_ch
);

    ede_pkg::q_push_t q_push;
    ede_pkg::q_head_t q_head;
    logic             q_full;
    logic             q_pop;

    // classify incoming words
    ede_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push)
    );

    // command queue
    ede_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    // string store and cost-row walker
    ede_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .q_pop  (q_pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// ===== design/ede_front.sv =====
`default_nettype none

module ede_front (
    ede_in_if.sink            in_ch,
    input  logic              q_full,
    output ede_pkg::q_push_t  q_push
);

    logic known_op;

    // unused opcode is taken and dropped here
    assign known_op = (in_ch.opcode == ede_pkg::OP_SRC) ||
                      (in_ch.opcode == ede_pkg::OP_TGT) ||
                      (in_ch.opcode == ede_pkg::OP_RUN);

    // accept whenever the queue has room
    assign in_ch.ready = !q_full;

    // forward only meaningful commands
    assign q_push.push          = in_ch.valid && !q_full && known_op;
    assign q_push.cmd.op        = in_ch.opcode;
    assign q_push.cmd.char_byte = in_ch.char_byte;

endmodule

`default_nettype wire

// ===== design/ede_fifo.sv =====
`default_nettype none

module ede_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  ede_pkg::q_push_t  q_push,
    output logic              q_full,
    input  logic              q_pop,
    output ede_pkg::q_head_t  q_head
);

    localparam int DEPTH = ede_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ede_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign q_full       = (count_reg == CW'(DEPTH));
    assign q_head.avail = (count_reg != '0);
    assign q_head.cmd   = slot_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_head.avail;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/ede_back.sv =====
`default_nettype none

module ede_back #(
    parameter int MAX_LEN = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ede_pkg::q_head_t  q_head,
    output logic              q_pop,
    ede_out_if.source         out_ch
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int JW = $clog2(MAX_LEN + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_CELL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] src_len_reg, src_len_next;
    logic [LW-1:0] tgt_len_reg, tgt_len_next;
    logic          drop_reg, drop_next;
    logic [LW-1:0] i_reg, i_next;
    logic [JW-1:0] jr_reg, jr_next;
    logic          ev_reg, ev_next;
    logic [LW-1:0] ej_reg, ej_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] res_reg, res_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ede_pkg::DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic                        out_ovf_reg, out_ovf_next;

    // character and row stores
    logic [ede_pkg::CHAR_W-1:0] src_mem [MAX_LEN];
    logic [ede_pkg::CHAR_W-1:0] tgt_mem [MAX_LEN];
    logic [LW-1:0]              row_mem [MAX_LEN];
    logic [ede_pkg::CHAR_W-1:0] src_rd_reg;
    logic [ede_pkg::CHAR_W-1:0] tgt_rd_reg;
    logic [LW-1:0]              row_rd_reg;

    logic          src_we, tgt_we, row_we, src_re, col_re;
    logic [AW-1:0] src_waddr, tgt_waddr, row_waddr, src_raddr, col_raddr;
    logic [LW-1:0] i_m1, ej_m1;
    logic [JW-1:0] col_issue, col_m1;
    logic          issue;

    logic [LW-1:0] up;
    logic [LW:0]   up_inc, left_inc, sub_cost, min_a, min_b;
    logic [LW-1:0] best;
    logic          out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    // one cell of the cost row
    assign up       = (i_reg == LW'(1)) ? ej_reg : row_rd_reg;
    assign up_inc   = {1'b0, up} + (LW+1)'(1);
    assign left_inc = {1'b0, left_reg} + (LW+1)'(1);
    assign sub_cost = {1'b0, diag_reg} + (LW+1)'(src_rd_reg != tgt_rd_reg);
    assign min_a    = (up_inc < left_inc) ? up_inc : left_inc;
    assign min_b    = (min_a < sub_cost) ? min_a : sub_cost;
    assign best     = min_b[LW-1:0];

    // column issue for the next read
    assign col_issue = (state_reg == S_ROW) ? JW'(1) : jr_reg;
    assign col_m1    = col_issue - JW'(1);
    assign col_raddr = col_m1[AW-1:0];
    assign issue     = ((state_reg == S_ROW) ||
                        ((state_reg == S_CELL) && (col_issue <= JW'(tgt_len_reg))));
    assign col_re    = issue;

    assign i_m1      = i_reg - LW'(1);
    assign src_raddr = i_m1[AW-1:0];
    assign src_re    = (state_reg == S_ROW);

    assign ej_m1     = ej_reg - LW'(1);
    assign row_waddr = ej_m1[AW-1:0];
    assign row_we    = (state_reg == S_CELL) && ev_reg;

    assign src_waddr = src_len_reg[AW-1:0];
    assign tgt_waddr = tgt_len_reg[AW-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        src_len_next   = src_len_reg;
        tgt_len_next   = tgt_len_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        jr_next        = jr_reg;
        ev_next        = 1'b0;
        ej_next        = ej_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;
        q_pop          = 1'b0;
        src_we         = 1'b0;
        tgt_we         = 1'b0;

        if (issue)
        begin
            ev_next = 1'b1;
            ej_next = LW'(col_issue);
            jr_next = col_issue + JW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_head.avail)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.cmd.op)
                        ede_pkg::OP_SRC:
                        begin
                            if (src_len_reg < LW'(MAX_LEN))
                            begin
                                src_we       = 1'b1;
                                src_len_next = src_len_reg + LW'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        ede_pkg::OP_TGT:
                        begin
                            if (tgt_len_reg < LW'(MAX_LEN))
                            begin
                                tgt_we       = 1'b1;
                                tgt_len_next = tgt_len_reg + LW'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        ede_pkg::OP_RUN:
                        begin
                            if ((src_len_reg == '0) || (tgt_len_reg == '0))
                            begin
                                // one side empty: distance is the other length
                                res_next   = src_len_reg | tgt_len_reg;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                i_next     = LW'(1);
                                state_next = S_ROW;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                // column zero is implicit: diag is i-1, left is i
                diag_next  = i_m1;
                left_next  = i_reg;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                if (ev_reg)
                begin
                    left_next = best;
                    diag_next = up;
                end
                else if (i_reg == src_len_reg)
                begin
                    res_next   = left_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    state_next = S_ROW;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = (32'(res_reg) > 32'(ede_pkg::DIST_MAX)) ?
                                     ede_pkg::DIST_MAX : ede_pkg::DIST_W'(res_reg);
                    out_ovf_next   = drop_reg;
                    src_len_next   = '0;
                    tgt_len_next   = '0;
                    drop_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_len_reg   <= '0;
            tgt_len_reg   <= '0;
            drop_reg      <= 1'b0;
            ev_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_len_reg   <= src_len_next;
            tgt_len_reg   <= tgt_len_next;
            drop_reg      <= drop_next;
            ev_reg        <= ev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        jr_reg       <= jr_next;
        ej_reg       <= ej_next;
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        res_reg      <= res_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // string and row stores with registered reads
    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_waddr] <= q_head.cmd.char_byte;
        end
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= q_head.cmd.char_byte;
        end
        if (row_we)
        begin
            row_mem[row_waddr] <= best;
        end
        if (src_re)
        begin
            src_rd_reg <= src_mem[src_raddr];
        end
        if (col_re)
        begin
            tgt_rd_reg <= tgt_mem[col_raddr];
            row_rd_reg <= row_mem[col_raddr];
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.distance = out_dist_reg;
    assign out_ch.overflow = out_ovf_reg;

    // a cell is only in flight while walking a row
    a_ev_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg |-> (state_reg == S_CELL))
        else $error("cell in flight outside row walk");

    // row index stays within the source string
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ROW) || (state_reg == S_CELL)) |->
        ((i_reg != '0) && (i_reg <= src_len_reg) && (tgt_len_reg != '0)))
        else $error("row index out of range");

    // lengths never pass capacity
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (src_len_reg <= LW'(MAX_LEN)) && (tgt_len_reg <= LW'(MAX_LEN)))
        else $error("string length beyond capacity");

    // a finished compute is presented next cycle once the output is free
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not presented");

endmodule

`default_nettype wire
